// ----- rtl/core/lwcc_pkg.sv -----
package lwcc_pkg;

    localparam int SUM_W  = 28;
    localparam int CNT_W  = 13;
    localparam int IDX_W  = 12;
    localparam int DAT_W  = 16;
    localparam int CFG_AW = 3;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [16:0]      SCAN_POINTS  = 17'd4096;
    localparam logic [DAT_W-1:0] MIN_RANGE_MM = 16'd10;
    localparam logic [CNT_W-1:0] COUNT_MAX    = 13'd8191;
    localparam logic [SUM_W:0]   SUM_MAX      = 29'h0FFF_FFFF;

    localparam logic [CFG_AW-1:0] CFG_LEFT_START  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_LEFT_END    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_RIGHT_START = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_RIGHT_END   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_GAIN        = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_MAX_ANG     = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_FWD_SPEED   = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_DFLT_DIST   = 3'd7;

    localparam logic [9:0]       GAIN_RESET      = 10'd205;
    localparam logic [14:0]      MAX_ANG_RESET   = 15'd1000;
    localparam logic [DAT_W-1:0] FWD_SPEED_RESET = 16'd200;
    localparam logic [DAT_W-1:0] DFLT_DIST_RESET = 16'd10000;

    typedef struct packed {
        logic [IDX_W-1:0] lwin_lo;
        logic [IDX_W-1:0] lwin_hi;
        logic [IDX_W-1:0] rwin_lo;
        logic [IDX_W-1:0] rwin_hi;
        logic [9:0]       gain;
        logic [14:0]      max_ang;
        logic [DAT_W-1:0] fwd_speed;
        logic [DAT_W-1:0] dflt_dist;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] left_sum;
        logic [CNT_W-1:0] left_cnt;
        logic [SUM_W-1:0] right_sum;
        logic [CNT_W-1:0] right_cnt;
    } t_job;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_MUL,
        BS_FIN
    } t_bstate;

endpackage

// ----- rtl/core/lwcc_if.sv -----
interface lwcc_sample_if;
    logic                        valid;
    logic                        ready;
    logic [lwcc_pkg::DAT_W-1:0]  range_mm;
    logic                        range_finite;
    logic [lwcc_pkg::IDX_W-1:0]  sample_index;
    logic                        last_sample;

    modport source (output valid, range_mm, range_finite, sample_index, last_sample,
                    input ready);
    modport sink   (input valid, range_mm, range_finite, sample_index, last_sample,
                    output ready);
endinterface

interface lwcc_cmd_if;
    logic                              valid;
    logic                              ready;
    logic signed [lwcc_pkg::DAT_W-1:0] turn_rate;
    logic [lwcc_pkg::DAT_W-1:0]        linear_cmd;
    logic [lwcc_pkg::DAT_W-1:0]        lwall_mm;
    logic [lwcc_pkg::DAT_W-1:0]        rwall_mm;

    modport source (output valid, turn_rate, linear_cmd, lwall_mm, rwall_mm,
                    input ready);
    modport sink   (input valid, turn_rate, linear_cmd, lwall_mm, rwall_mm,
                    output ready);
endinterface

interface lwcc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lwcc_pkg::CFG_AW-1:0] index;
    logic [lwcc_pkg::DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lwcc_front.sv -----
module lwcc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lwcc_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lwcc_pkg::DAT_W-1:0]  i_range_mm,
    input  logic                        i_range_finite,
    input  logic [lwcc_pkg::IDX_W-1:0]  i_sample_index,
    input  logic                        i_last_sample,
    input  logic                        i_q_ready,
    output logic                        o_q_push,
    output lwcc_pkg::t_job              o_q_job
);

    logic [lwcc_pkg::SUM_W-1:0] r_lsum, n_lsum, r_rsum, n_rsum;
    logic [lwcc_pkg::CNT_W-1:0] r_lcnt, n_lcnt, r_rcnt, n_rcnt;
    logic                       take, good, in_left, in_right;
    logic [lwcc_pkg::SUM_W:0]   lsum_ext, rsum_ext;

    assign o_ready = i_q_ready;
    assign take    = i_valid & i_q_ready;

    always_comb begin
        good = i_range_finite && (i_range_mm > lwcc_pkg::MIN_RANGE_MM) &&
               ({5'd0, i_sample_index} < lwcc_pkg::SCAN_POINTS);
        in_left  = good && (i_sample_index >= i_cfg.lwin_lo) &&
                   (i_sample_index < i_cfg.lwin_hi);
        in_right = good && (i_sample_index >= i_cfg.rwin_lo) &&
                   (i_sample_index < i_cfg.rwin_hi);
        lsum_ext = {1'b0, r_lsum} + {13'd0, i_range_mm};
        rsum_ext = {1'b0, r_rsum} + {13'd0, i_range_mm};
        n_lsum = r_lsum;
        n_lcnt = r_lcnt;
        n_rsum = r_rsum;
        n_rcnt = r_rcnt;
        if (in_left && (r_lcnt < lwcc_pkg::COUNT_MAX) && (lsum_ext <= lwcc_pkg::SUM_MAX)) begin
            n_lsum = lsum_ext[lwcc_pkg::SUM_W-1:0];
            n_lcnt = r_lcnt + 13'd1;
        end
        if (in_right && (r_rcnt < lwcc_pkg::COUNT_MAX) && (rsum_ext <= lwcc_pkg::SUM_MAX)) begin
            n_rsum = rsum_ext[lwcc_pkg::SUM_W-1:0];
            n_rcnt = r_rcnt + 13'd1;
        end
    end

    assign o_q_push = take & i_last_sample;
    assign o_q_job  = '{left_sum: n_lsum, left_cnt: n_lcnt,
                        right_sum: n_rsum, right_cnt: n_rcnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsum <= '0;
            r_lcnt <= '0;
            r_rsum <= '0;
            r_rcnt <= '0;
        end else if (take) begin
            if (i_last_sample) begin
                r_lsum <= '0;
                r_lcnt <= '0;
                r_rsum <= '0;
                r_rcnt <= '0;
            end else begin
                r_lsum <= n_lsum;
                r_lcnt <= n_lcnt;
                r_rsum <= n_rsum;
                r_rcnt <= n_rcnt;
            end
        end
    end

endmodule

// ----- rtl/core/lwcc_fifo.sv -----
module lwcc_fifo #(
    parameter int DEPTH = lwcc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lwcc_pkg::t_job i_job,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output lwcc_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    lwcc_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && o_ready) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (i_pop && o_valid) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            case ({i_push && o_ready, i_pop && o_valid})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/core/lwcc_div.sv -----
module lwcc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lwcc_pkg::SUM_W-1:0] i_dividend,
    input  logic [lwcc_pkg::CNT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [lwcc_pkg::SUM_W-1:0] o_quot
);

    localparam int STW = $clog2(lwcc_pkg::SUM_W + 1);

    logic [lwcc_pkg::SUM_W-1:0] r_quo;
    logic [lwcc_pkg::CNT_W-1:0] r_rem, r_dvs;
    logic [STW-1:0]             r_step;
    logic                       r_busy, r_done;
    logic [lwcc_pkg::CNT_W:0]   rem_sh;
    logic [lwcc_pkg::CNT_W+1:0] diff;

    assign rem_sh = {r_rem, r_quo[lwcc_pkg::SUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[lwcc_pkg::CNT_W+1]) begin
                r_rem <= diff[lwcc_pkg::CNT_W-1:0];
                r_quo <= {r_quo[lwcc_pkg::SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[lwcc_pkg::CNT_W-1:0];
                r_quo <= {r_quo[lwcc_pkg::SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STW'(lwcc_pkg::SUM_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - STW'(1);
                end
            end
        end
    end

endmodule

// ----- rtl/core/lwcc_back.sv -----
module lwcc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lwcc_pkg::t_cfg                    i_cfg,
    input  logic                              i_q_valid,
    input  lwcc_pkg::t_job                    i_q_job,
    output logic                              o_q_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [lwcc_pkg::DAT_W-1:0] o_turn_rate,
    output logic [lwcc_pkg::DAT_W-1:0]        o_linear_cmd,
    output logic [lwcc_pkg::DAT_W-1:0]        o_lwall_mm,
    output logic [lwcc_pkg::DAT_W-1:0]        o_rwall_mm
);

    lwcc_pkg::t_bstate r_state, n_state;

    logic                       start, ldiv_done, rdiv_done, load_out;
    logic [lwcc_pkg::SUM_W-1:0] lquot, rquot;
    logic                       r_lzero, r_rzero, r_ovalid;
    logic [lwcc_pkg::DAT_W-1:0] ld, rd, r_ld, r_rd;
    logic signed [16:0]         r_err;
    logic signed [27:0]         r_prod, negp;
    logic signed [19:0]         shifted, clamped, mpos;

    lwcc_div u_ldiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (i_q_job.left_sum),
        .i_divisor  (i_q_job.left_cnt),
        .o_done     (ldiv_done),
        .o_quot     (lquot)
    );

    lwcc_div u_rdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (i_q_job.right_sum),
        .i_divisor  (i_q_job.right_cnt),
        .o_done     (rdiv_done),
        .o_quot     (rquot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lwcc_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        start    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            lwcc_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    start   = 1'b1;
                    n_state = lwcc_pkg::BS_DIV;
                end
            end
            lwcc_pkg::BS_DIV: begin
                if (ldiv_done && rdiv_done) begin
                    n_state = lwcc_pkg::BS_MUL;
                end
            end
            lwcc_pkg::BS_MUL: begin
                n_state = lwcc_pkg::BS_FIN;
            end
            lwcc_pkg::BS_FIN: begin
                if (!r_ovalid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = lwcc_pkg::BS_IDLE;
                end
            end
            default: n_state = lwcc_pkg::BS_IDLE;
        endcase
    end

    assign o_q_pop = start;

    always_comb begin
        ld      = r_lzero ? i_cfg.dflt_dist : lquot[lwcc_pkg::DAT_W-1:0];
        rd      = r_rzero ? i_cfg.dflt_dist : rquot[lwcc_pkg::DAT_W-1:0];
        negp    = -r_prod;
        shifted = 20'(negp >>> 8);
        mpos    = $signed({5'd0, i_cfg.max_ang});
        if (shifted > mpos) begin
            clamped = mpos;
        end else if (shifted < -mpos) begin
            clamped = -mpos;
        end else begin
            clamped = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_lzero <= (i_q_job.left_cnt == '0);
            r_rzero <= (i_q_job.right_cnt == '0);
        end
        if (r_state == lwcc_pkg::BS_DIV && ldiv_done && rdiv_done) begin
            r_ld  <= ld;
            r_rd  <= rd;
            r_err <= $signed({1'b0, rd}) - $signed({1'b0, ld});
        end
        if (r_state == lwcc_pkg::BS_MUL) begin
            r_prod <= $signed({18'd0, i_cfg.gain}) * $signed({{11{r_err[16]}}, r_err});
        end
        if (load_out) begin
            o_turn_rate  <= clamped[lwcc_pkg::DAT_W-1:0];
            o_linear_cmd <= i_cfg.fwd_speed;
            o_lwall_mm   <= r_ld;
            o_rwall_mm   <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;

endmodule

// ----- rtl/core/lidar_wall_centering_controller_top.sv -----
// Throughput: one sample beat per cycle while the queue has room. The back
// end takes one scan at a time; one bit-serial divider (28 steps) per side.
// Finished scans wait in a short queue, so samples keep flowing meanwhile.
// Reset: synchronous active low; sums, counts and queue cleared, registers
// return to defaults (gain 205, max 1000, speed 200, default distance 10000).
module lidar_wall_centering_controller_top #(
    parameter int QUEUE_DEPTH = lwcc_pkg::QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lwcc_sample_if.sink   i_sample,
    lwcc_cmd_if.source    o_cmd,
    lwcc_cfg_if.sink      i_cfg
);

    lwcc_pkg::t_cfg r_cfg;
    lwcc_pkg::t_job push_job, pop_job;
    logic           q_ready, q_push, q_valid, q_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lwin_lo   <= '0;
            r_cfg.lwin_hi   <= '0;
            r_cfg.rwin_lo   <= '0;
            r_cfg.rwin_hi   <= '0;
            r_cfg.gain      <= lwcc_pkg::GAIN_RESET;
            r_cfg.max_ang   <= lwcc_pkg::MAX_ANG_RESET;
            r_cfg.fwd_speed <= lwcc_pkg::FWD_SPEED_RESET;
            r_cfg.dflt_dist <= lwcc_pkg::DFLT_DIST_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lwcc_pkg::CFG_LEFT_START:  r_cfg.lwin_lo   <= i_cfg.data[11:0];
                lwcc_pkg::CFG_LEFT_END:    r_cfg.lwin_hi   <= i_cfg.data[11:0];
                lwcc_pkg::CFG_RIGHT_START: r_cfg.rwin_lo   <= i_cfg.data[11:0];
                lwcc_pkg::CFG_RIGHT_END:   r_cfg.rwin_hi   <= i_cfg.data[11:0];
                lwcc_pkg::CFG_GAIN:        r_cfg.gain      <= i_cfg.data[9:0];
                lwcc_pkg::CFG_MAX_ANG:     r_cfg.max_ang   <= i_cfg.data[14:0];
                lwcc_pkg::CFG_FWD_SPEED:   r_cfg.fwd_speed <= i_cfg.data;
                lwcc_pkg::CFG_DFLT_DIST:   r_cfg.dflt_dist <= i_cfg.data;
                default:                   r_cfg           <= r_cfg;
            endcase
        end
    end

    lwcc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_sample.valid),
        .o_ready        (i_sample.ready),
        .i_range_mm     (i_sample.range_mm),
        .i_range_finite (i_sample.range_finite),
        .i_sample_index (i_sample.sample_index),
        .i_last_sample  (i_sample.last_sample),
        .i_q_ready      (q_ready),
        .o_q_push       (q_push),
        .o_q_job        (push_job)
    );

    lwcc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    lwcc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_job      (pop_job),
        .o_q_pop      (q_pop),
        .o_valid      (o_cmd.valid),
        .i_ready      (o_cmd.ready),
        .o_turn_rate  (o_cmd.turn_rate),
        .o_linear_cmd (o_cmd.linear_cmd),
        .o_lwall_mm   (o_cmd.lwall_mm),
        .o_rwall_mm   (o_cmd.rwall_mm)
    );

endmodule

// ----- rtl/core/lwcc_chk.sv -----
module lwcc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [15:0] i_angular,
    input logic [15:0] i_linear,
    input logic [15:0] i_left,
    input logic [15:0] i_right
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("command beat valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("command beat dropped before taken");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_angular) && $stable(i_linear) &&
                                $stable(i_left) && $stable(i_right))
        else $error("stalled command beat changed");

    a_centered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_left == i_right) |-> (i_angular == 16'd0))
        else $error("nonzero turn with equal wall distances");

    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_right > i_left) |-> ($signed(i_angular) <= 0))
        else $error("turn sign wrong for right wall farther");

endmodule

bind lidar_wall_centering_controller_top lwcc_chk u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_cmd.valid),
    .i_ready   (o_cmd.ready),
    .i_angular (o_cmd.turn_rate),
    .i_linear  (o_cmd.linear_cmd),
    .i_left    (o_cmd.lwall_mm),
    .i_right   (o_cmd.rwall_mm)
);
